// ===== rtl/itf_pkg.sv =====
// Shared types and constants for the integer to IEEE-754 converter.
// Used by itf_normalize and int_to_ieee_float_convert_core; no dependencies.
`default_nettype none

package itf_pkg;

   typedef enum logic [2:0] {
      MODE_S64_F64 = 3'd0,
      MODE_U64_F64 = 3'd1,
      MODE_U32_F64 = 3'd2,
      MODE_U64_F32 = 3'd3,
      MODE_U32_F32 = 3'd4
   } mode_type;

   localparam int unsigned VALUE_W  = 64;
   localparam int unsigned LZ_W     = 6;
   localparam int unsigned DBL_EXP_W  = 11;
   localparam int unsigned DBL_FRAC_W = 52;
   localparam int unsigned SGL_EXP_W  = 8;
   localparam int unsigned SGL_FRAC_W = 23;

   // Bias plus the position of the top bit of a 64-bit word.
   localparam logic [DBL_EXP_W-1:0] DBL_EXP_TOP = DBL_EXP_W'(1023 + 63);
   localparam logic [SGL_EXP_W-1:0] SGL_EXP_TOP = SGL_EXP_W'(127 + 63);

   // Control that travels alongside the datapath of one item.
   typedef struct packed {
      logic valid;
      logic sign;
      logic single;
      logic zero;
   } ctl_type;

endpackage

`default_nettype wire

// ===== rtl/itf_normalize.sv =====
// Two-stage normaliser: leading-zero count, then left shift.
// Depends on itf_pkg for the control struct and widths.
`default_nettype none

module itf_normalize (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  itf_pkg::ctl_type           ctl_i,
   input  wire  [itf_pkg::VALUE_W-1:0]      mag_i,
   output itf_pkg::ctl_type                 ctl_o,
   output logic [itf_pkg::LZ_W-1:0]         lz_o,
   output logic [itf_pkg::VALUE_W-1:0]      norm_o
);
   import itf_pkg::*;

   ctl_type              lzc_ctl_ff, lzc_ctl_in;
   logic [VALUE_W-1:0]   lzc_mag_ff;
   logic [LZ_W-1:0]      lzc_lz_ff, lzc_lz_in;

   ctl_type              sh_ctl_ff, sh_ctl_in;
   logic [VALUE_W-1:0]   sh_norm_ff, sh_norm_in;
   logic [LZ_W-1:0]      sh_lz_ff;

   // Binary search for the leading one, halving the window each step.
   always_comb begin
      logic [VALUE_W-1:0] v;
      v = mag_i;
      lzc_lz_in = '0;
      if (v[63:32] == '0) begin
         lzc_lz_in[5] = 1'b1;
         v = v << 32;
      end
      if (v[63:48] == '0) begin
         lzc_lz_in[4] = 1'b1;
         v = v << 16;
      end
      if (v[63:56] == '0) begin
         lzc_lz_in[3] = 1'b1;
         v = v << 8;
      end
      if (v[63:60] == '0) begin
         lzc_lz_in[2] = 1'b1;
         v = v << 4;
      end
      if (v[63:62] == '0) begin
         lzc_lz_in[1] = 1'b1;
         v = v << 2;
      end
      if (v[63] == 1'b0) begin
         lzc_lz_in[0] = 1'b1;
      end
      lzc_ctl_in = ctl_i;
   end

   always_comb begin
      sh_norm_in = lzc_mag_ff << lzc_lz_ff;
      sh_ctl_in  = lzc_ctl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lzc_ctl_ff <= '0;
         sh_ctl_ff  <= '0;
      end else begin
         lzc_ctl_ff <= lzc_ctl_in;
         sh_ctl_ff  <= sh_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      lzc_mag_ff <= mag_i;
      lzc_lz_ff  <= lzc_lz_in;
      sh_norm_ff <= sh_norm_in;
      sh_lz_ff   <= lzc_lz_ff;
   end

   assign ctl_o  = sh_ctl_ff;
   assign lz_o   = sh_lz_ff;
   assign norm_o = sh_norm_ff;

endmodule

`default_nettype wire

// ===== rtl/int_to_ieee_float_convert_core.sv =====
// Top level of the integer to IEEE-754 converter (truncating, no rounding).
// Depends on itf_pkg and itf_normalize.
//
// Usage:
//   Raise start with req_mode and req_value; the item is taken at that clock
//   edge. busy is always low, so a new item may be presented every cycle.
//   Modes: signed 64 to double, unsigned 64 to double, unsigned 32 to double,
//   unsigned 64 to single, unsigned 32 to single; other codes give zero.
//   An item passes through four register stages (operand magnitude,
//   leading-zero count, left shift, field packing) before its result is
//   shown on rsp_float_bits with rsp_valid high.
//   Throughput: one item per cycle, since every stage takes a new item in
//   each cycle and nothing ever waits.
//   The result is shown for exactly one cycle; the receiver cannot stall
//   the block, so nothing is held back.
//   Reset (synchronous, active high) clears the valid bits of all stages, so
//   items in flight are dropped and no result appears until new items arrive.
`default_nettype none

module int_to_ieee_float_convert_core (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire  [2:0]                    req_mode,
   input  wire  [itf_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   output logic [itf_pkg::VALUE_W-1:0]   rsp_float_bits
);
   import itf_pkg::*;

   ctl_type              op_ctl_ff, op_ctl_in;
   logic [VALUE_W-1:0]   op_mag_ff, op_mag_in;

   ctl_type              nrm_ctl;
   logic [LZ_W-1:0]      nrm_lz;
   logic [VALUE_W-1:0]   nrm_norm;

   logic                 out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]   out_bits_ff, out_bits_in;

   assign busy = 1'b0;

   // Stage 1: choose the magnitude and the sign for the mode.
   always_comb begin
      op_ctl_in       = '0;
      op_ctl_in.valid = start;
      op_mag_in       = '0;
      case (req_mode)
         MODE_S64_F64: begin
            op_ctl_in.sign = req_value[VALUE_W-1];
            op_mag_in      = req_value[VALUE_W-1] ? (~req_value + 64'd1) : req_value;
         end
         MODE_U64_F64: op_mag_in = req_value;
         MODE_U32_F64: op_mag_in = {32'd0, req_value[31:0]};
         MODE_U64_F32: begin
            op_ctl_in.single = 1'b1;
            op_mag_in        = req_value;
         end
         MODE_U32_F32: begin
            op_ctl_in.single = 1'b1;
            op_mag_in        = {32'd0, req_value[31:0]};
         end
         default: op_mag_in = '0;
      endcase
      op_ctl_in.zero = (op_mag_in == '0);
   end

   itf_normalize u_normalize (
      .clock  (clock),
      .reset  (reset),
      .ctl_i  (op_ctl_ff),
      .mag_i  (op_mag_ff),
      .ctl_o  (nrm_ctl),
      .lz_o   (nrm_lz),
      .norm_o (nrm_norm)
   );

   // Final stage: exponent from the leading-zero count, fraction truncated.
   always_comb begin
      logic [DBL_EXP_W-1:0] dbl_exp;
      logic [SGL_EXP_W-1:0] sgl_exp;
      dbl_exp      = DBL_EXP_TOP - DBL_EXP_W'(nrm_lz);
      sgl_exp      = SGL_EXP_TOP - SGL_EXP_W'(nrm_lz);
      out_valid_in = nrm_ctl.valid;
      if (nrm_ctl.zero) begin
         out_bits_in = '0;
      end else if (nrm_ctl.single) begin
         out_bits_in = {32'd0, 1'b0, sgl_exp, nrm_norm[62 -: SGL_FRAC_W]};
      end else begin
         out_bits_in = {nrm_ctl.sign, dbl_exp, nrm_norm[62 -: DBL_FRAC_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ctl_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         op_ctl_ff    <= op_ctl_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_mag_ff   <= op_mag_in;
      out_bits_ff <= out_bits_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_float_bits = out_bits_ff;

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 4))
      else $error("result without an item taken four cycles earlier");

   a_normalised: assert property (@(posedge clock) disable iff (reset)
      (nrm_ctl.valid && !nrm_ctl.zero) |-> nrm_norm[VALUE_W-1])
      else $error("shifted operand has no leading one at the top");

   a_single_upper: assert property (@(posedge clock) disable iff (reset)
      (nrm_ctl.valid && nrm_ctl.single) |=> (rsp_float_bits[63:32] == 32'd0))
      else $error("single result has upper bits set");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (nrm_ctl.valid && nrm_ctl.zero) |=> (rsp_float_bits == '0))
      else $error("zero operand gave a nonzero result");
`endif

endmodule

`default_nettype wire
